>>> hdl/mtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// shared types and codes of the multi timer table
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam logic [1:0] REQ_SET      = 2'd0;
    localparam logic [1:0] REQ_KILL     = 2'd1;
    localparam logic [1:0] REQ_KILL_ALL = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    localparam logic [2:0] KIND_OK        = 3'd0;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd1;
    localparam logic [2:0] KIND_REJECTED  = 3'd2;
    localparam logic [2:0] KIND_FIRED     = 3'd3;
    localparam logic [2:0] KIND_NO_FIRE   = 3'd4;

    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [15:0] CELL_RESET = 16'd50;
    localparam int          MAX_RESULTS = 16;
    localparam int          NFIRE_W     = 5;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] period;
        logic [31:0] repeats;
        logic [31:0] tag;
        logic [31:0] remaining;
    } t_entry;

endpackage
`default_nettype wire

>>> hdl/multi_timer_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_timer_table
// table of software timers with repeat counts, kept packed in insertion
// order in one synchronous memory; set, kill, kill-all and tick requests
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   req_type timer_id period repeat_count tag
//  out       output     o_out_valid / i_out_ready result_kind fired_id fired_tag last
//  cfg       input      i_cfg_we                  tick_cell (16 bits)
//
//  one request at a time; each table entry is read, then evaluated
//  set: rounding divider, then a scan of every entry, then the write
//  kill: scan up to the match, then shift each later entry down; tick: scan of every entry
//  idle ticks, kill-all and sets with a zero period or repeat count skip the table scan
//  reset is synchronous; the table needs no clearing pass
//  a full output register stalls the tick scan at the next reported firing
// ----------------------------------------------------------------------------
module multi_timer_table #(
    parameter int TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_timer_id,
    input  wire logic [31:0] i_period,
    input  wire logic [31:0] i_repeat_count,
    input  wire logic [31:0] i_tag,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_fired_id,
    output logic [31:0]      o_fired_tag,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int EW = $bits(mtt_pkg::t_entry);
    localparam int NFIRE_W_L = mtt_pkg::NFIRE_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV     = 4'd1;
    localparam logic [3:0] S_SRD     = 4'd2;
    localparam logic [3:0] S_SEV     = 4'd3;
    localparam logic [3:0] S_SFIN    = 4'd4;
    localparam logic [3:0] S_KRD     = 4'd5;
    localparam logic [3:0] S_KEV     = 4'd6;
    localparam logic [3:0] S_KSH_RD  = 4'd7;
    localparam logic [3:0] S_KSH_WR  = 4'd8;
    localparam logic [3:0] S_TRD     = 4'd9;
    localparam logic [3:0] S_TEV     = 4'd10;
    localparam logic [3:0] S_TEND    = 4'd11;
    localparam logic [3:0] S_RESP    = 4'd12;

    logic [3:0]           r_state;
    logic [15:0]          r_cell;
    logic [CW-1:0]        r_active;
    logic [31:0]          r_passed;
    logic [31:0]          r_until;
    logic [CW-1:0]        r_ri;
    logic [CW-1:0]        r_wi;
    logic [IW-1:0]        r_midx;
    logic                 r_match;
    logic [31:0]          r_min;
    logic [31:0]          r_q;
    logic [31:0]          r_id;
    logic [31:0]          r_rep;
    logic [31:0]          r_tag;
    logic [2:0]           r_kind;
    logic                 r_pend;
    logic [31:0]          r_pend_id;
    logic [31:0]          r_pend_tag;
    logic [NFIRE_W_L-1:0] r_nfire;
    logic                 r_out_valid;
    logic [2:0]           r_out_kind;
    logic [31:0]          r_out_id;
    logic [31:0]          r_out_tag;
    logic                 r_out_last;

    logic [EW-1:0] mem [TIMERS];
    logic [EW-1:0] r_rdata;

    logic          mem_re;
    logic [IW-1:0] mem_ra;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;

    logic          out_free;
    logic          out_load;
    logic [2:0]    out_kind;
    logic [31:0]   out_id;
    logic [31:0]   out_tag;
    logic          out_last;

    logic [15:0]   cell_val;
    logic [32:0]   passed_sum;
    logic [31:0]   passed_next;
    logic [31:0]   until_next;
    logic [32:0]   rem_sum;
    logic [31:0]   rem_sat;
    logic [CW-1:0] ri_p1;

    mtt_pkg::t_entry e;
    logic [31:0]   rem1;
    logic          fire;
    logic          report;
    logic          retired;
    logic          tev_stall;
    logic [31:0]   newrep;
    logic [31:0]   newrem;
    mtt_pkg::t_entry wentry;

    logic          rnd_start;
    logic          rnd_done;
    logic [31:0]   rnd_q;

    mtt_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rnd_start),
        .i_period (i_period),
        .i_cell   (cell_val),
        .o_done   (rnd_done),
        .o_q      (rnd_q)
    );

    assign cell_val    = (r_cell == 16'd0) ? 16'd1 : r_cell;
    assign passed_sum  = {1'b0, r_passed} + {17'd0, cell_val};
    assign passed_next = passed_sum[32] ? mtt_pkg::ALL_ONES : passed_sum[31:0];
    assign until_next  = (r_until > {16'd0, cell_val}) ? r_until - {16'd0, cell_val} : 32'd0;
    assign rem_sum     = {1'b0, r_q} + {1'b0, r_passed};
    assign rem_sat     = rem_sum[32] ? mtt_pkg::ALL_ONES : rem_sum[31:0];
    assign ri_p1       = r_ri + CW'(1);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign rnd_start   = i_in_valid && o_in_ready && i_req_type == mtt_pkg::REQ_SET
                         && i_period != 32'd0 && i_repeat_count != 32'd0;

    assign e         = mtt_pkg::t_entry'(r_rdata);
    assign rem1      = (e.remaining <= r_passed) ? 32'd0 : e.remaining - r_passed;
    assign fire      = (rem1 == 32'd0);
    assign report    = fire && (r_nfire < NFIRE_W_L'(mtt_pkg::MAX_RESULTS));
    assign retired   = fire && e.repeats != mtt_pkg::ALL_ONES && e.repeats <= 32'd1;
    assign tev_stall = report && r_pend && !out_free;
    assign newrep    = (fire && e.repeats != mtt_pkg::ALL_ONES) ? e.repeats - 32'd1 : e.repeats;
    assign newrem    = fire ? e.period : rem1;

    always_comb begin
        mem_re   = 1'b0;
        mem_ra   = r_ri[IW-1:0];
        mem_we   = 1'b0;
        mem_wa   = r_wi[IW-1:0];
        wentry   = e;
        out_load = 1'b0;
        out_kind = r_kind;
        out_id   = '0;
        out_tag  = '0;
        out_last = 1'b1;
        unique case (r_state)
            S_SRD, S_KRD, S_TRD: begin
                mem_re = (r_ri != r_active);
            end
            S_SFIN: begin
                mem_we           = r_match || (r_active != CW'(TIMERS));
                mem_wa           = r_match ? r_midx : r_active[IW-1:0];
                wentry.ident     = r_id;
                wentry.period    = r_q;
                wentry.repeats   = r_rep;
                wentry.tag       = r_tag;
                wentry.remaining = rem_sat;
            end
            S_KSH_RD: begin
                mem_re = (ri_p1 < r_active);
                mem_ra = ri_p1[IW-1:0];
            end
            S_KSH_WR: begin
                mem_we = 1'b1;
                mem_wa = r_ri[IW-1:0];
            end
            S_TEV: begin
                if (!tev_stall) begin
                    if (report && r_pend) begin
                        out_load = 1'b1;
                        out_kind = mtt_pkg::KIND_FIRED;
                        out_id   = r_pend_id;
                        out_tag  = r_pend_tag;
                        out_last = 1'b0;
                    end
                    mem_we           = !retired;
                    wentry.repeats   = newrep;
                    wentry.remaining = newrem;
                end
            end
            S_TEND: begin
                out_load = out_free;
                out_kind = r_pend ? mtt_pkg::KIND_FIRED : mtt_pkg::KIND_NO_FIRE;
                out_id   = r_pend ? r_pend_id : 32'd0;
                out_tag  = r_pend ? r_pend_tag : 32'd0;
            end
            S_RESP: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign mem_wd = wentry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_id   <= out_id;
            r_out_tag  <= out_tag;
            r_out_last <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= mtt_pkg::CELL_RESET;
        end else if (i_cfg_we) begin
            r_cell <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_passed <= '0;
            r_until  <= mtt_pkg::ALL_ONES;
            r_pend   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_id    <= i_timer_id;
                        r_rep   <= i_repeat_count;
                        r_tag   <= i_tag;
                        r_ri    <= '0;
                        r_wi    <= '0;
                        r_match <= 1'b0;
                        r_midx  <= '0;
                        r_min   <= r_until;
                        r_kind  <= mtt_pkg::KIND_OK;
                        r_state <= S_RESP;
                        unique case (i_req_type)
                            mtt_pkg::REQ_SET: begin
                                if (i_period == 32'd0 || i_repeat_count == 32'd0) begin
                                    r_kind <= mtt_pkg::KIND_REJECTED;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            mtt_pkg::REQ_KILL: begin
                                r_state <= S_KRD;
                            end
                            mtt_pkg::REQ_KILL_ALL: begin
                                r_active <= '0;
                                r_passed <= '0;
                                r_until  <= mtt_pkg::ALL_ONES;
                            end
                            mtt_pkg::REQ_TICK: begin
                                r_kind <= mtt_pkg::KIND_NO_FIRE;
                                if (r_until != mtt_pkg::ALL_ONES) begin
                                    r_passed <= passed_next;
                                    r_until  <= until_next;
                                    if (until_next == 32'd0) begin
                                        r_pend  <= 1'b0;
                                        r_nfire <= '0;
                                        r_min   <= mtt_pkg::ALL_ONES;
                                        r_state <= S_TRD;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (rnd_done) begin
                        r_q     <= rnd_q;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= (r_ri == r_active) ? S_SFIN : S_SEV;
                end
                S_SEV: begin
                    if (e.ident == r_id) begin
                        r_match <= 1'b1;
                        r_midx  <= r_ri[IW-1:0];
                    end else if (e.remaining < r_min) begin
                        r_min <= e.remaining;
                    end
                    r_ri    <= ri_p1;
                    r_state <= S_SRD;
                end
                S_SFIN: begin
                    if (!r_match && r_active == CW'(TIMERS)) begin
                        r_kind <= mtt_pkg::KIND_REJECTED;
                    end else begin
                        if (!r_match) begin
                            r_active <= r_active + CW'(1);
                        end
                        r_until <= (r_q < r_min) ? r_q : r_min;
                    end
                    r_state <= S_RESP;
                end
                S_KRD: begin
                    if (r_ri == r_active) begin
                        r_kind  <= mtt_pkg::KIND_NOT_FOUND;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_KEV;
                    end
                end
                S_KEV: begin
                    if (e.ident == r_id) begin
                        r_state <= S_KSH_RD;
                    end else begin
                        r_ri    <= ri_p1;
                        r_state <= S_KRD;
                    end
                end
                S_KSH_RD: begin
                    if (ri_p1 < r_active) begin
                        r_state <= S_KSH_WR;
                    end else begin
                        r_active <= r_active - CW'(1);
                        if (r_active == CW'(1)) begin
                            r_passed <= '0;
                            r_until  <= mtt_pkg::ALL_ONES;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_KSH_WR: begin
                    r_ri    <= ri_p1;
                    r_state <= S_KSH_RD;
                end
                S_TRD: begin
                    r_state <= (r_ri == r_active) ? S_TEND : S_TEV;
                end
                S_TEV: begin
                    if (!tev_stall) begin
                        if (report) begin
                            r_pend     <= 1'b1;
                            r_pend_id  <= e.ident;
                            r_pend_tag <= e.tag;
                            r_nfire    <= r_nfire + NFIRE_W_L'(1);
                        end
                        if (!retired) begin
                            r_wi <= r_wi + CW'(1);
                            if (newrem < r_min) begin
                                r_min <= newrem;
                            end
                        end
                        r_ri    <= ri_p1;
                        r_state <= S_TRD;
                    end
                end
                S_TEND: begin
                    if (out_free) begin
                        r_active <= r_wi;
                        r_passed <= '0;
                        r_until  <= r_min;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_fired_id    = r_out_id;
    assign o_fired_tag   = r_out_tag;
    assign o_last        = r_out_last;

`ifndef SYNTH
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CW'(TIMERS))
        else $error("timer count beyond table size");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != mtt_pkg::KIND_FIRED) |-> o_last)
        else $error("non-firing result not marked last");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_active == '0) |-> (r_until == mtt_pkg::ALL_ONES))
        else $error("empty table not idle");
`endif

endmodule
`default_nettype wire

>>> hdl/mtt_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_round
// rounds a period up to a multiple of the tick cell, saturating; restoring
// divider one quotient bit a cycle, then one multiply and a final add
// ----------------------------------------------------------------------------
module mtt_round (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_period,
    input  wire logic [15:0] i_cell,
    output logic             o_done,
    output logic [31:0]      o_q
);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_DIV  = 2'd1;
    localparam logic [1:0] R_MUL  = 2'd2;
    localparam logic [1:0] R_FIN  = 2'd3;

    logic [1:0]  r_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_cell;
    logic [47:0] r_prod;
    logic [31:0] r_q;
    logic        r_done;

    logic [16:0] trial;
    logic        take;
    logic [16:0] diff;
    logic [32:0] up;

    assign trial = {r_rem, r_quo[31]};
    assign take  = trial >= {1'b0, r_cell};
    assign diff  = trial - {1'b0, r_cell};
    assign up    = {1'b0, r_prod[31:0]} + {17'd0, r_cell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_quo   <= i_period;
                        r_rem   <= '0;
                        r_cell  <= i_cell;
                        r_cnt   <= '0;
                        r_state <= R_DIV;
                    end
                end
                R_DIV: begin
                    r_rem <= take ? diff[15:0] : trial[15:0];
                    r_quo <= {r_quo[30:0], take};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= R_MUL;
                    end
                end
                R_MUL: begin
                    r_prod  <= r_quo * r_cell;
                    r_state <= R_FIN;
                end
                R_FIN: begin
                    if (r_rem != '0 && !up[32]) begin
                        r_q <= up[31:0];
                    end else begin
                        r_q <= r_prod[31:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= R_IDLE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
`default_nettype wire

>>> test/tb_multi_timer_table.sv
// ----------------------------------------------------------------------------
// tb_multi_timer_table
// self-checking bench for the timer table: directed requests from a table,
// then random set/kill/kill-all/tick traffic under several idling phases and tick
// cell settings; every result beat is checked against a behavioral model
// ----------------------------------------------------------------------------
module tb_multi_timer_table;

    localparam int NTIM = 16;
    localparam int WDOG = 20000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] tag;
        logic        last;
    } t_res;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] id;
        logic [31:0] per;
        logic [31:0] rep;
        logic [31:0] tag;
        bit          typed;
        logic [2:0]  kind;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [31:0] i_timer_id;
    logic [31:0] i_period;
    logic [31:0] i_repeat_count;
    logic [31:0] i_tag;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_result_kind;
    logic [31:0] o_fired_id;
    logic [31:0] o_fired_tag;
    logic        o_last;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    multi_timer_table #(.TIMERS(NTIM)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_timer_id(i_timer_id), .i_period(i_period),
        .i_repeat_count(i_repeat_count), .i_tag(i_tag),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_kind(o_result_kind), .o_fired_id(o_fired_id),
        .o_fired_tag(o_fired_tag), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // timer model state
    logic [15:0] m_cell;
    logic [31:0] m_ident [NTIM];
    logic [31:0] m_period [NTIM];
    logic [31:0] m_reps [NTIM];
    logic [31:0] m_tag [NTIM];
    logic [31:0] m_remain [NTIM];
    logic [31:0] m_passed;
    logic [31:0] m_until;
    int          m_count;

    t_res pending_results[$];
    int   errors = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   fires_seen = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   recv_stall = 0;

    function automatic void push_result(logic [2:0] k, logic [31:0] id, logic [31:0] tg);
        t_res r;
        r.kind = k; r.id = id; r.tag = tg; r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void drop_slot(int i);
        for (int j = i; j + 1 < m_count; j++) begin
            m_ident[j] = m_ident[j+1]; m_period[j] = m_period[j+1];
            m_reps[j] = m_reps[j+1]; m_tag[j] = m_tag[j+1];
            m_remain[j] = m_remain[j+1];
        end
        m_count--;
    endfunction

    function automatic void go_idle();
        m_passed = 0;
        m_until = mtt_pkg::ALL_ONES;
    endfunction

    function automatic logic [2:0] model_set(logic [31:0] id, logic [31:0] per,
                                            logic [31:0] rep, logic [31:0] tg);
        logic [63:0] c;
        logic [63:0] q;
        logic [63:0] rem;
        int slot;
        c = (m_cell == 0) ? 64'd1 : 64'(m_cell);
        slot = -1;
        if (per == 0 || rep == 0) return mtt_pkg::KIND_REJECTED;
        q = (64'(per) + c - 1) / c * c;
        if (q > 64'(mtt_pkg::ALL_ONES)) q = (64'(mtt_pkg::ALL_ONES) / c) * c;
        for (int i = 0; i < m_count; i++)
            if (slot < 0 && m_ident[i] == id) slot = i;
        if (slot < 0) begin
            if (m_count >= NTIM) return mtt_pkg::KIND_REJECTED;
            slot = m_count;
            m_count++;
        end
        rem = q + 64'(m_passed);
        if (rem > 64'(mtt_pkg::ALL_ONES)) rem = 64'(mtt_pkg::ALL_ONES);
        m_ident[slot] = id; m_period[slot] = q[31:0]; m_reps[slot] = rep;
        m_tag[slot] = tg; m_remain[slot] = rem[31:0];
        for (int i = 0; i < m_count; i++)
            if (m_remain[i] < m_until) m_until = m_remain[i];
        if (q[31:0] < m_until) m_until = q[31:0];
        return mtt_pkg::KIND_OK;
    endfunction

    function automatic void model_tick();
        logic [31:0] c;
        logic [31:0] nxt;
        int i;
        int n;
        bit gone;
        c = (m_cell == 0) ? 32'd1 : 32'(m_cell);
        nxt = mtt_pkg::ALL_ONES;
        i = 0;
        n = 0;
        if (m_until == mtt_pkg::ALL_ONES) begin
            push_result(mtt_pkg::KIND_NO_FIRE, 0, 0);
            return;
        end
        m_passed = (m_passed > mtt_pkg::ALL_ONES - c) ? mtt_pkg::ALL_ONES : m_passed + c;
        m_until = (m_until > c) ? m_until - c : 0;
        if (m_until != 0) begin
            push_result(mtt_pkg::KIND_NO_FIRE, 0, 0);
            return;
        end
        while (i < m_count) begin
            gone = 0;
            m_remain[i] = (m_remain[i] <= m_passed) ? 0 : m_remain[i] - m_passed;
            if (m_remain[i] == 0) begin
                if (n < mtt_pkg::MAX_RESULTS) begin
                    push_result(mtt_pkg::KIND_FIRED, m_ident[i], m_tag[i]);
                    n++;
                end
                if (m_reps[i] != mtt_pkg::ALL_ONES) begin
                    if (m_reps[i] <= 1) begin
                        gone = 1;
                        drop_slot(i);
                    end else begin
                        m_reps[i]--;
                    end
                end
                if (!gone) m_remain[i] = m_period[i];
            end
            if (!gone) begin
                if (m_remain[i] < nxt) nxt = m_remain[i];
                i++;
            end
        end
        m_passed = 0;
        m_until = nxt;
        if (n == 0) push_result(mtt_pkg::KIND_NO_FIRE, 0, 0);
    endfunction

    function automatic void predict_request(logic [1:0] rq, logic [31:0] id, logic [31:0] per,
                                            logic [31:0] rep, logic [31:0] tg);
        int hit;
        hit = -1;
        case (rq)
            mtt_pkg::REQ_SET: push_result(model_set(id, per, rep, tg), 0, 0);
            mtt_pkg::REQ_KILL: begin
                for (int i = 0; i < m_count; i++)
                    if (hit < 0 && m_ident[i] == id) hit = i;
                if (hit >= 0) begin
                    drop_slot(hit);
                    if (m_count == 0) go_idle();
                    push_result(mtt_pkg::KIND_OK, 0, 0);
                end else begin
                    push_result(mtt_pkg::KIND_NOT_FOUND, 0, 0);
                end
            end
            mtt_pkg::REQ_KILL_ALL: begin
                m_count = 0;
                go_idle();
                push_result(mtt_pkg::KIND_OK, 0, 0);
            end
            default: model_tick();
        endcase
        pending_results[$].last = 1'b1;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_in_ready && i_in_valid) beats_in++;
            if (o_out_valid && i_out_ready) begin
                t_res e;
                beats_out++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat kind=%0d id=%h tag=%h last=%b",
                                 o_result_kind, o_fired_id, o_fired_tag, o_last);
                end else begin
                    e = pending_results.pop_front();
                    if (o_result_kind == mtt_pkg::KIND_FIRED) fires_seen++;
                    if (o_result_kind !== e.kind || o_fired_id !== e.id ||
                        o_fired_tag !== e.tag || o_last !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("exp k=%0d id=%h tag=%h l=%b got k=%0d id=%h tag=%h l=%b",
                                     e.kind, e.id, e.tag, e.last,
                                     o_result_kind, o_fired_id, o_fired_tag, o_last);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall);
            if ((o_in_ready && i_in_valid) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(logic [1:0] rq, logic [31:0] id, logic [31:0] per,
                        logic [31:0] rep, logic [31:0] tg);
        while ($urandom_range(99) < send_gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_request(rq, id, per, rep, tg);
        i_in_valid <= 1'b1;
        i_req_type <= rq; i_timer_id <= id; i_period <= per;
        i_repeat_count <= rep; i_tag <= tg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_cell(logic [15:0] v);
        drain();
        m_cell = v;
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_request(int n_ids);
        int pick;
        logic [31:0] per;
        logic [31:0] rep;
        pick = $urandom_range(99);
        per = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(400, 1);
        rep = ($urandom_range(4) == 0) ? mtt_pkg::ALL_ONES : $urandom_range(4, 1);
        if ($urandom_range(19) == 0) per = 0;
        if ($urandom_range(19) == 0) rep = ($urandom_range(1) ? 32'd0 : $urandom());
        if (pick < 30)
            send(mtt_pkg::REQ_SET, $urandom_range(n_ids - 1), per, rep, $urandom());
        else if (pick < 40)
            send(mtt_pkg::REQ_KILL,
                 ($urandom_range(9) == 0) ? $urandom() : $urandom_range(n_ids - 1),
                 $urandom(), $urandom(), $urandom());
        else if (pick < 43)
            send(mtt_pkg::REQ_KILL_ALL, $urandom(), $urandom(), $urandom(), $urandom());
        else
            send(mtt_pkg::REQ_TICK, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    t_row dir_rows[$];

    function automatic void add_row(logic [1:0] rq, logic [31:0] id, logic [31:0] per,
                                    logic [31:0] rep, logic [31:0] tg, bit typed,
                                    logic [2:0] k);
        t_row r;
        r.req = rq; r.id = id; r.per = per; r.rep = rep; r.tag = tg;
        r.typed = typed; r.kind = k;
        dir_rows.push_back(r);
    endfunction

    initial begin
        logic [15:0] cells [5];
        t_res chk;
        cells = '{16'd10, 16'd65535, 16'd0, 16'd3, 16'd137};
        i_rst_n = 0; i_in_valid = 0; i_req_type = 0; i_timer_id = 0; i_period = 0;
        i_repeat_count = 0; i_tag = 0; i_out_ready = 1; i_cfg_we = 0; i_cfg_wdata = 0;
        m_cell = mtt_pkg::CELL_RESET; m_count = 0; go_idle();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 1, mtt_pkg::KIND_NO_FIRE);
        add_row(mtt_pkg::REQ_KILL, 32'hFFFF_FFFF, 0, 0, 0, 1, mtt_pkg::KIND_NOT_FOUND);
        add_row(mtt_pkg::REQ_SET, 1, 0, 5, 1, 1, mtt_pkg::KIND_REJECTED);
        add_row(mtt_pkg::REQ_SET, 1, 5, 0, 1, 1, mtt_pkg::KIND_REJECTED);
        add_row(mtt_pkg::REQ_SET, 32'hFFFF_FFFF, mtt_pkg::ALL_ONES, mtt_pkg::ALL_ONES,
                mtt_pkg::ALL_ONES, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_SET, 0, 1, 1, 32'hA5A5_5A5A, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_SET, 7, 120, 2, 32'h5A5A_A5A5, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_SET, 8, 49, mtt_pkg::ALL_ONES, 32'h1234, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
        add_row(mtt_pkg::REQ_SET, 7, 60, 1, 9, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_KILL, 8, 0, 0, 0, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
        add_row(mtt_pkg::REQ_KILL_ALL, 0, 0, 0, 0, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 1, mtt_pkg::KIND_NO_FIRE);
        for (int k = 0; k < NTIM; k++)
            add_row(mtt_pkg::REQ_SET, 100 + k, 50, 1, k, 1, mtt_pkg::KIND_OK);
        add_row(mtt_pkg::REQ_SET, 999, 50, 1, 0, 1, mtt_pkg::KIND_REJECTED);
        add_row(mtt_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);

        foreach (dir_rows[r]) begin
            send(dir_rows[r].req, dir_rows[r].id, dir_rows[r].per, dir_rows[r].rep,
                 dir_rows[r].tag);
            if (dir_rows[r].typed) begin
                chk = pending_results[$];
                if (chk.kind !== dir_rows[r].kind) begin
                    errors++;
                    if (errors <= 10)
                        $display("row %0d: model kind %0d, table says %0d",
                                 r, chk.kind, dir_rows[r].kind);
                end
                pending_results[$].kind = dir_rows[r].kind;
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            set_cell(cells[ph]);
            case (ph % 4)
                0: begin send_gap = 0; recv_stall = 0; end
                1: begin send_gap = 59; recv_stall = 0; end
                2: begin send_gap = 0; recv_stall = 59; end
                default: begin send_gap = 24; recv_stall = 24; end
            endcase
            for (int k = 0; k < 53; k++) random_request((ph == 4) ? 24 : 6);
        end
        send_gap = 0;
        recv_stall = 0;
        drain();
        set_cell(mtt_pkg::CELL_RESET);

        $display("%0d request beats, %0d result beats, %0d timer firings",
                 beats_in, beats_out, fires_seen);
        $display("tick cells 10, 65535, 0, 3, 137 and 50 under four idling mixes");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/mtt_pkg.sv
hdl/mtt_round.sv
hdl/multi_timer_table.sv
test/tb_multi_timer_table.sv
